// File: hw/rtl/windowed_median_position_filter_core_defines.svh
// ---------------------------------------------------------------------------
// Windowed median position filter: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef WINDOWED_MEDIAN_POSITION_FILTER_CORE_DEFINES_SVH
`define WINDOWED_MEDIAN_POSITION_FILTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define WMPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("wmpf assertion failed");
`define WMPF_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("wmpf forbidden condition seen");
`else
`define WMPF_ASSERT(lbl, clk, rstn, prop)
`define WMPF_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: hw/rtl/wmpf_pkg.sv
// ---------------------------------------------------------------------------
// Windowed median position filter package
// Widths, types and helpers shared by the cell chain and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wmpf_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int COORD_W    = 40;
  localparam int NUM_AXES   = 3;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);

  localparam int AX_EAST   = 0;
  localparam int AX_NORTH  = 1;
  localparam int AX_HEIGHT = 2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [NUM_AXES-1:0][COORD_W-1:0] fix_t;
  typedef logic [NUM_AXES-1:0][SLOT_W-1:0]  rank_t;

  typedef struct packed {
    fix_t  val;
    slot_t idx;
  } probe_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic step;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RANK,
    ST_PICK,
    ST_EMIT
  } state_e;

  function automatic len_t eff_len(input len_t raw);
    len_t res;
    res = raw;
    if (raw == '0) begin
      res = len_t'(1);
    end else if (raw > len_t'(WINDOW_MAX)) begin
      res = len_t'(WINDOW_MAX);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wmpf_cell.sv
// ---------------------------------------------------------------------------
// Window cell
// Holds one fix of the window and a circulating probe; counts, per axis,
// how many window entries order below its own entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wmpf_cell
  import wmpf_pkg::*;
(
  input  wire        clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire slot_t      cell_idx_i,
  input  wire fix_t       val_i,
  input  wire probe_t     probe_i,
  output fix_t       val_o,
  output probe_t     probe_o,
  output rank_t      rank_o
);

  fix_t   val_q;
  probe_t probe_q, probe_d;
  rank_t  rank_q, rank_d;
  logic [NUM_AXES-1:0] below;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      below[a] = ($signed(probe_q.val[a]) < $signed(val_q[a])) ||
                 ((probe_q.val[a] == val_q[a]) && (probe_q.idx < cell_idx_i));
    end
  end

  always_comb begin
    probe_d = probe_q;
    rank_d  = rank_q;
    if (ctrl_i.load) begin
      probe_d = '{val: val_q, idx: cell_idx_i};
      rank_d  = '0;
    end else if (ctrl_i.step) begin
      probe_d = probe_i;
      for (int a = 0; a < NUM_AXES; a++) begin
        rank_d[a] = rank_q[a] + slot_t'(below[a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      val_q <= val_i;
    end
    probe_q <= probe_d;
    rank_q  <= rank_d;
  end

  assign val_o   = val_q;
  assign probe_o = probe_q;
  assign rank_o  = rank_q;

endmodule

`default_nettype wire

// File: hw/rtl/windowed_median_position_filter_core.sv
// ---------------------------------------------------------------------------
// Windowed median position filter core
// Per-axis median of the last window_len valid position fixes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one fix per transaction.
//   A fix with fix_valid_i low is dropped and gives no result.
//   A valid fix shifts into a chain of WINDOW_MAX cells; once the window
//   holds n = window_len fixes, the fix gives one result transaction on the
//   output channel (out_valid_o / out_stall_i).
//   Ranking circulates every entry past each of the n window cells, one
//   cell a cycle; a producing fix passes through LOAD, RANK, PICK and EMIT,
//   and input stalls until the core is idle again. Fixes that give no
//   result leave the core idle, so it can take the next fix.
//   cfg_we_i writes window_len (0 acts as 1, above 16 acts as 16) and
//   empties the window; write it only while the block is idle.
//   Reset: window empty, window_len 1, no result pending.
//   A stalled result holds in the output register; the core waits with the
//   next result until it is taken, and stalls input meanwhile.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_median_position_filter_core_defines.svh"

module windowed_median_position_filter_core
  import wmpf_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire  [LEN_W-1:0]          cfg_wdata_i,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire                       fix_valid_i,
  input  wire  signed [COORD_W-1:0] east_mm_i,
  input  wire  signed [COORD_W-1:0] north_mm_i,
  input  wire  signed [COORD_W-1:0] height_mm_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic signed [COORD_W-1:0] median_east_mm_o,
  output logic signed [COORD_W-1:0] median_north_mm_o,
  output logic signed [COORD_W-1:0] median_height_mm_o
);

  state_e     state_q, state_d;
  len_t       len_q, len_d;
  len_t       fill_q, fill_d;
  len_t       step_cnt_q, step_cnt_d;
  logic       out_valid_q, out_valid_d;
  fix_t       out_fix_q;
  fix_t       lo_q, hi_q, lo_d, hi_d;
  fix_t       med_d;
  fix_t       in_fix;
  cell_ctrl_t cell_ctrl;
  logic       in_take, push, pick_en, emit_en, out_free;
  len_t       len_m1, fill_nxt, lo_half, hi_half;
  slot_t      lo_rank, hi_rank;
  probe_t     ring_probe;
  logic signed [COORD_W:0] sum;

  fix_t   cell_val   [WINDOW_MAX];
  probe_t cell_probe [WINDOW_MAX];
  rank_t  cell_rank  [WINDOW_MAX];

  assign in_fix[AX_EAST]   = east_mm_i;
  assign in_fix[AX_NORTH]  = north_mm_i;
  assign in_fix[AX_HEIGHT] = height_mm_i;

  assign len_m1     = len_q - len_t'(1);
  assign ring_probe = cell_probe[len_m1[SLOT_W-1:0]];
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fill_nxt   = (fill_q < len_q) ? fill_q + len_t'(1) : len_q;

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    wmpf_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .cell_idx_i (slot_t'(g)),
      .val_i      ((g == 0) ? in_fix : cell_val[(g == 0) ? 0 : g - 1]),
      .probe_i    ((g == 0) ? ring_probe : cell_probe[(g == 0) ? 0 : g - 1]),
      .val_o      (cell_val[g]),
      .probe_o    (cell_probe[g]),
      .rank_o     (cell_rank[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take && fix_valid_i && !cfg_we_i && (fill_nxt == len_q)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_RANK;
      ST_RANK: begin
        if (step_cnt_q == len_m1) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    push    = (state_q == ST_IDLE) && in_take && fix_valid_i && !cfg_we_i;
    pick_en = (state_q == ST_PICK);
    emit_en = (state_q == ST_EMIT) && out_free;
    cell_ctrl.shift = push;
    cell_ctrl.load  = (state_q == ST_LOAD);
    cell_ctrl.step  = (state_q == ST_RANK);
  end

  always_comb begin
    len_d      = len_q;
    fill_d     = fill_q;
    step_cnt_d = step_cnt_q;
    if (cfg_we_i) begin
      len_d  = eff_len(cfg_wdata_i);
      fill_d = '0;
    end else if (push) begin
      fill_d = fill_nxt;
    end
    if (cell_ctrl.load) begin
      step_cnt_d = '0;
    end else if (cell_ctrl.step) begin
      step_cnt_d = step_cnt_q + len_t'(1);
    end
    out_valid_d = emit_en ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // pick the two middle entries by rank
  always_comb begin
    lo_half = len_m1 >> 1;
    hi_half = len_q >> 1;
    lo_rank = lo_half[SLOT_W-1:0];
    hi_rank = hi_half[SLOT_W-1:0];
    lo_d    = '0;
    hi_d    = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (len_t'(i) < len_q) begin
          if (cell_rank[i][a] == lo_rank) begin
            lo_d[a] = lo_d[a] | cell_val[i][a];
          end
          if (cell_rank[i][a] == hi_rank) begin
            hi_d[a] = hi_d[a] | cell_val[i][a];
          end
        end
      end
    end
  end

  // floor of the mean of the two middle entries
  always_comb begin
    sum   = '0;
    med_d = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      sum = $signed({lo_q[a][COORD_W-1], lo_q[a]}) +
            $signed({hi_q[a][COORD_W-1], hi_q[a]});
      med_d[a] = sum[COORD_W:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= len_t'(1);
      fill_q      <= '0;
      step_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      step_cnt_q  <= step_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pick_en) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (emit_en) begin
      out_fix_q <= med_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign median_east_mm_o   = $signed(out_fix_q[AX_EAST]);
  assign median_north_mm_o  = $signed(out_fix_q[AX_NORTH]);
  assign median_height_mm_o = $signed(out_fix_q[AX_HEIGHT]);

  `WMPF_NEVER(a_fill_in_len, clk_i, rst_ni, fill_q > len_q)
  `WMPF_NEVER(a_len_range, clk_i, rst_ni, (len_q == '0) || (len_q > len_t'(WINDOW_MAX)))
  `WMPF_ASSERT(a_load_full, clk_i, rst_ni, (state_q == ST_LOAD) |-> (fill_q == len_q))
  `WMPF_ASSERT(a_rank_start, clk_i, rst_ni, (state_q == ST_LOAD) |=> ((state_q == ST_RANK) && (step_cnt_q == '0)))
  `WMPF_ASSERT(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))

endmodule

`default_nettype wire

// File: test/windowed_median_position_filter_core_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Windowed median position filter: result checker
// Watches the configuration port and both channels, keeps its own copy of
// the per-axis fix windows, predicts the median of every producing fix and
// compares each accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
module windowed_median_position_filter_core_checker
  import wmpf_pkg::*;
(
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire  [LEN_W-1:0]          cfg_wdata_i,
  input  wire                       in_valid_i,
  input  wire                       in_stall_i,
  input  wire                       fix_valid_i,
  input  wire  signed [COORD_W-1:0] east_mm_i,
  input  wire  signed [COORD_W-1:0] north_mm_i,
  input  wire  signed [COORD_W-1:0] height_mm_i,
  input  wire                       out_valid_i,
  input  wire                       out_stall_i,
  input  wire  signed [COORD_W-1:0] median_east_mm_i,
  input  wire  signed [COORD_W-1:0] median_north_mm_i,
  input  wire  signed [COORD_W-1:0] median_height_mm_i,
  output int                        errors_o,
  output int                        pending_o
);

  typedef struct packed {
    logic signed [COORD_W-1:0] east;
    logic signed [COORD_W-1:0] north;
    logic signed [COORD_W-1:0] height;
  } median_t;

  logic signed [COORD_W-1:0] fix_window [NUM_AXES][WINDOW_MAX];
  logic [LEN_W-1:0]          len_raw;
  int unsigned               next_slot;
  int unsigned               fill_level;
  int                        mismatch_cnt;
  median_t                   pending_medians [$];

  function automatic int unsigned span_of(input logic [LEN_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (raw > WINDOW_MAX) begin
      return WINDOW_MAX;
    end
    return int'(raw);
  endfunction

  function automatic logic signed [COORD_W-1:0] window_median(input int axis,
                                                             input int unsigned n);
    logic signed [COORD_W-1:0] sorted [WINDOW_MAX];
    logic signed [COORD_W-1:0] key;
    logic signed [COORD_W:0]   pair_sum;
    int                        j;
    for (int i = 0; i < n; i++) begin
      sorted[i] = fix_window[axis][i];
    end
    for (int i = 1; i < n; i++) begin
      key = sorted[i];
      j   = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    if (n % 2 == 1) begin
      return sorted[n/2];
    end
    pair_sum = sorted[n/2] + sorted[n/2-1];
    return pair_sum[COORD_W:1];
  endfunction

  function automatic void absorb_fix(input logic signed [COORD_W-1:0] east,
                                     input logic signed [COORD_W-1:0] north,
                                     input logic signed [COORD_W-1:0] height);
    int unsigned n;
    median_t     med;
    n = span_of(len_raw);
    if (next_slot >= n) begin
      next_slot = 0;
    end
    fix_window[AX_EAST][next_slot]   = east;
    fix_window[AX_NORTH][next_slot]  = north;
    fix_window[AX_HEIGHT][next_slot] = height;
    next_slot = (next_slot + 1 >= n) ? 0 : next_slot + 1;
    if (fill_level < n) begin
      fill_level++;
    end
    if (fill_level == n) begin
      med.east   = window_median(AX_EAST, n);
      med.north  = window_median(AX_NORTH, n);
      med.height = window_median(AX_HEIGHT, n);
      pending_medians.push_back(med);
    end
  endfunction

  function automatic void check_field(input string name,
                                      input logic signed [COORD_W-1:0] want,
                                      input logic signed [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    median_t want;
    if (!rst_ni) begin
      pending_medians.delete();
      len_raw      = LEN_W'(1);
      next_slot    = 0;
      fill_level   = 0;
      mismatch_cnt = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_medians.size() == 0) begin
          $error("median result with no fix waiting: east %0d north %0d height %0d",
                 median_east_mm_i, median_north_mm_i, median_height_mm_i);
          mismatch_cnt++;
        end else begin
          want = pending_medians.pop_front();
          check_field("median_east_mm", want.east, median_east_mm_i);
          check_field("median_north_mm", want.north, median_north_mm_i);
          check_field("median_height_mm", want.height, median_height_mm_i);
        end
      end
      if (cfg_we_i) begin
        len_raw    = cfg_wdata_i;
        next_slot  = 0;
        fill_level = 0;
      end
      if (in_valid_i && !in_stall_i && fix_valid_i) begin
        absorb_fix(east_mm_i, north_mm_i, height_mm_i);
      end
      errors_o  <= mismatch_cnt;
      pending_o <= pending_medians.size();
    end
  end

endmodule

// File: test/windowed_median_position_filter_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Windowed median position filter core testbench
// Drives directed extremes and then random phases of position fixes over
// many window lengths, with random gaps and output stalls, and reports the
// checker's verdict once every predicted median has been taken.
// ---------------------------------------------------------------------------
module windowed_median_position_filter_core_test;
  import wmpf_pkg::*;

  localparam int                        NUM_FIXES = 1250;
  localparam int                        SETTLE_CYCLES = 32;
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [LEN_W-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      fix_valid_i;
  logic signed [COORD_W-1:0] east_mm_i;
  logic signed [COORD_W-1:0] north_mm_i;
  logic signed [COORD_W-1:0] height_mm_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [COORD_W-1:0] median_east_mm_o;
  logic signed [COORD_W-1:0] median_north_mm_o;
  logic signed [COORD_W-1:0] median_height_mm_o;
  int                        mismatches;
  int                        medians_pending;

  always #1 clk_i = ~clk_i;

  windowed_median_position_filter_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .fix_valid_i        (fix_valid_i),
    .east_mm_i          (east_mm_i),
    .north_mm_i         (north_mm_i),
    .height_mm_i        (height_mm_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .median_east_mm_o   (median_east_mm_o),
    .median_north_mm_o  (median_north_mm_o),
    .median_height_mm_o (median_height_mm_o)
  );

  windowed_median_position_filter_core_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .fix_valid_i        (fix_valid_i),
    .east_mm_i          (east_mm_i),
    .north_mm_i         (north_mm_i),
    .height_mm_i        (height_mm_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .median_east_mm_i   (median_east_mm_o),
    .median_north_mm_i  (median_north_mm_o),
    .median_height_mm_i (median_height_mm_o),
    .errors_o           (mismatches),
    .pending_o          (medians_pending)
  );

  function automatic logic signed [COORD_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(
      input logic signed [COORD_W-1:0] centre,
      input logic signed [COORD_W-1:0] prev);
    int d;
    unique case ($urandom_range(0, 15))
      0: return C_MIN;
      1: return C_MAX;
      2, 3: return rand_word();
      4: return prev;
      5: begin
        d = $urandom_range(0, 16) - 8;
        return COORD_W'(d);
      end
      default: begin
        d = $urandom_range(0, 2000) - 1000;
        return centre + COORD_W'(d);
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) begin
      return 0;
    end
    if (r < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(20, 60);
  endfunction

  // Offer one fix and hold it until the transaction completes.
  task automatic send_fix(input logic fv,
                          input logic signed [COORD_W-1:0] e,
                          input logic signed [COORD_W-1:0] n,
                          input logic signed [COORD_W-1:0] h);
    in_valid_i  <= 1'b1;
    fix_valid_i <= fv;
    east_mm_i   <= e;
    north_mm_i  <= n;
    height_mm_i <= h;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic quiet(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop valid, drain every predicted median, then let the core go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (medians_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] raw);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : receiver
    int  taken;
    int  stall_left;
    int  seg_left;
    int  mode;
    bit  held;
    taken      = 0;
    stall_left = 0;
    seg_left   = 0;
    mode       = 0;
    held       = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        taken++;
      end
      if (!held && taken >= 60) begin
        held       = 1'b1;
        stall_left = 300;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(16, 128);
      end
      seg_left--;
      if (stall_left == 0 && mode != 0 && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                 : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0]          raw;
    logic signed [COORD_W-1:0] ce;
    logic signed [COORD_W-1:0] cn;
    logic signed [COORD_W-1:0] ch;
    logic                      fv;
    int                        span;
    int                        count;
    int                        pause_at;
    int                        phase;
    int                        fixes_sent;
    int                        gap;
    bit                        burst;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    fix_valid_i <= 1'b0;
    east_mm_i   <= '0;
    north_mm_i  <= '0;
    height_mm_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset length of one
    send_fix(1'b1, C_MAX, C_MIN, 40'sd0);
    send_fix(1'b1, C_MIN, C_MAX, -40'sd1);
    send_fix(1'b0, C_MAX, C_MAX, C_MAX);
    send_fix(1'b1, 40'sd0, -40'sd1, 40'sd1);

    // even window: floor of the mean, extremes and negative halves
    write_len(LEN_W'(2));
    send_fix(1'b1, C_MAX, C_MAX, C_MIN);
    send_fix(1'b1, C_MAX, C_MIN, C_MIN);
    send_fix(1'b1, C_MIN, C_MIN, C_MAX);
    send_fix(1'b0, C_MIN, C_MIN, C_MIN);
    send_fix(1'b1, C_MIN, -40'sd1, 40'sd3);
    send_fix(1'b1, -40'sd1, -40'sd2, -40'sd3);
    send_fix(1'b1, -40'sd2, 40'sd1, 40'sd0);

    // zero acts as one
    write_len('0);
    send_fix(1'b1, 40'sd5, -40'sd5, C_MAX);
    send_fix(1'b0, 40'sd7, 40'sd7, 40'sd7);
    send_fix(1'b1, -40'sd9, C_MIN, 40'sd9);

    // odd window with wrap of the write slot
    write_len(LEN_W'(3));
    send_fix(1'b1, C_MAX, C_MIN, 40'sd0);
    send_fix(1'b1, C_MIN, 40'sd0, C_MAX);
    send_fix(1'b1, 40'sd0, C_MAX, C_MIN);
    send_fix(1'b1, 40'sd5, 40'sd5, 40'sd5);
    send_fix(1'b1, 40'sd5, 40'sd5, 40'sd5);

    fixes_sent = 0;
    phase      = 0;
    while (fixes_sent < NUM_FIXES) begin
      unique case (phase)
        0:       raw = LEN_W'(16);
        1:       raw = '1;
        2:       raw = LEN_W'(1);
        3:       raw = '0;
        4:       raw = LEN_W'(17);
        5:       raw = LEN_W'(2);
        default: raw = LEN_W'($urandom_range(0, 31));
      endcase
      write_len(raw);
      span     = (raw == 0) ? 1 : ((raw > WINDOW_MAX) ? WINDOW_MAX : int'(raw));
      count    = span + $urandom_range(8, 48);
      burst    = ($urandom_range(0, 3) == 0);
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, count - 1) : -1;
      ce       = rand_word();
      cn       = rand_word();
      ch       = rand_word();
      for (int k = 0; k < count; k++) begin
        fv = ($urandom_range(0, 9) != 0);
        send_fix(fv, pick_coord(ce, east_mm_i), pick_coord(cn, north_mm_i),
                 pick_coord(ch, height_mm_i));
        if (fv) begin
          fixes_sent++;
        end
        if (k == pause_at) begin
          settle();
        end else if (!burst) begin
          gap = pick_gap();
          if (gap > 0) begin
            quiet(gap);
          end
        end
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && medians_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/wmpf_pkg.sv
hw/rtl/wmpf_cell.sv
hw/rtl/windowed_median_position_filter_core.sv
test/windowed_median_position_filter_core_checker.sv
test/windowed_median_position_filter_core_test.sv
